[hw/rtl/dq_pkg.sv]
// Shared types and constants for the double-ended queue.
package dq_pkg;

  localparam int DATA_W      = 32;
  localparam int CMD_W       = 3;
  localparam int STATUS_W    = 2;
  localparam int MAX_RESULTS = 32;
  localparam int RUN_W       = $clog2(MAX_RESULTS);
  localparam int TDATA_W     = ((DATA_W + STATUS_W + 7) / 8) * 8;
  localparam int PAD_W       = TDATA_W - DATA_W - STATUS_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_PEEK_FRONT = 3'd4,
    CMD_PEEK_BACK  = 3'd5,
    CMD_LIST       = 3'd6
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

[hw/rtl/dq_ram.sv]
// Ring store of queue entries with one write port and one registered read port.
module dq_ram #(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [dq_pkg::DATA_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [dq_pkg::DATA_W-1:0] rdata
);
  import dq_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/dq_index.sv]
// Shared ring index unit: adds an offset to the head index modulo the depth.
module dq_index #(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic [AW-1:0] base,
  input  logic [AW-1:0] offset,
  output logic [AW-1:0] slot
);
  import dq_pkg::*;

  localparam logic [AW:0] DEPTH_W = (AW + 1)'(DEPTH);

  logic [AW:0] sum;

  always_comb begin
    sum = {1'b0, base} + {1'b0, offset};
    if (sum >= DEPTH_W) begin
      slot = AW'(sum - DEPTH_W);
    end else begin
      slot = sum[AW-1:0];
    end
  end

endmodule

[hw/rtl/double_ended_queue_core.sv]
// Top level of the double-ended queue: command sequencer, output register and ring store.
//
// Usage: each request enters on the s_ channel (s_tuser carries the command, s_tdata the
// value to push) and is accepted when s_tvalid and s_tready are both high. Every request
// gives at least one result on the m_ channel; m_tdata carries the value and the status,
// and m_tlast marks the final result of a request. A push to a full queue is dropped with
// status full; a pop, peek or listing on an empty queue gives one result with status empty.
// The listing request walks from the back toward the front and returns every second entry,
// at most 32 results.
// Timing: the block takes one request at a time. A push or an unused command ends in the
// execute state; a pop or peek on a non-empty queue goes on to the read state, and a listing
// passes through both states once per result. The read state comes from the single read port
// of the ring store, whose read is registered, and all addresses go through the one index adder.
// A result waits in the output register while the receiver stalls, and the walk pauses
// until it is taken. Reset empties the queue at once; the store needs no clearing pass.
module double_ended_queue_core #(
  parameter int DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [dq_pkg::DATA_W-1:0]  s_tdata,   // push_value [31:0]
  input  logic [dq_pkg::CMD_W-1:0]   s_tuser,   // cmd [2:0]
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [dq_pkg::TDATA_W-1:0] m_tdata,   // data_out [31:0], status [33:32], zeros
  output logic                       m_tlast
);
  import dq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } state_t;

  state_t                   state;
  cmd_t                     cmd_q;
  logic signed [DATA_W-1:0] val_q;
  logic [AW-1:0]            head;
  logic [CW-1:0]            count;
  logic [CW-1:0]            rem;
  logic [RUN_W-1:0]         runs;
  logic [DATA_W-1:0]        out_data;
  status_t                  out_status;
  logic                     out_last;

  logic              out_free;
  logic              is_empty;
  logic              is_full;
  logic              is_push;
  logic              is_read;
  logic              list_done;
  logic [AW-1:0]     offset;
  logic [AW-1:0]     slot;
  logic              ram_we;
  logic              ram_re;
  logic [DATA_W-1:0] rdata;

  assign out_free  = !m_tvalid || m_tready;
  assign is_empty  = (count == '0);
  assign is_full   = (count == CW'(DEPTH));
  assign is_push   = (cmd_q == CMD_PUSH_FRONT) || (cmd_q == CMD_PUSH_BACK);
  assign is_read   = (cmd_q == CMD_POP_FRONT) || (cmd_q == CMD_POP_BACK) ||
                     (cmd_q == CMD_PEEK_FRONT) || (cmd_q == CMD_PEEK_BACK) ||
                     (cmd_q == CMD_LIST);
  assign list_done = (rem < CW'(2)) || (runs == RUN_W'(MAX_RESULTS - 1));

  always_comb begin
    offset = '0;
    unique case (state)
      S_IDLE: offset = '0;
      S_EXEC: begin
        unique case (cmd_q)
          CMD_PUSH_FRONT: offset = AW'(DEPTH - 1);
          CMD_PUSH_BACK:  offset = count[AW-1:0];
          CMD_POP_FRONT,
          CMD_PEEK_FRONT: offset = '0;
          CMD_POP_BACK,
          CMD_PEEK_BACK:  offset = AW'(count - CW'(1));
          CMD_LIST:       offset = rem[AW-1:0];
          default:        offset = '0;
        endcase
      end
      S_READ: offset = AW'(1);
      default: offset = '0;
    endcase
  end

  dq_index #(.DEPTH(DEPTH)) u_index (
    .base   (head),
    .offset (offset),
    .slot   (slot)
  );

  assign ram_we = (state == S_EXEC) && out_free && is_push && !is_full;
  assign ram_re = (state == S_EXEC) && is_read && !is_empty;

  dq_ram #(.DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (val_q),
    .re    (ram_re),
    .raddr (slot),
    .rdata (rdata)
  );

  assign s_tready = (state == S_IDLE) && !rst;
  assign m_tdata  = {PAD_W'(0), out_status, out_data};
  assign m_tlast  = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      head     <= '0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd_q <= cmd_t'(s_tuser);
            val_q <= s_tdata;
            rem   <= count - CW'(1);
            runs  <= '0;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (is_push) begin
            if (out_free) begin
              out_data   <= '0;
              out_last   <= 1'b1;
              m_tvalid   <= 1'b1;
              state      <= S_IDLE;
              if (is_full) begin
                out_status <= ST_FULL;
              end else begin
                out_status <= ST_OK;
                count      <= count + CW'(1);
                if (cmd_q == CMD_PUSH_FRONT) begin
                  head <= slot;
                end
              end
            end
          end else if (is_read) begin
            if (!is_empty) begin
              state <= S_READ;
            end else if (out_free) begin
              out_data   <= '0;
              out_status <= ST_EMPTY;
              out_last   <= 1'b1;
              m_tvalid   <= 1'b1;
              state      <= S_IDLE;
            end
          end else if (out_free) begin
            out_data   <= '0;
            out_status <= ST_OK;
            out_last   <= 1'b1;
            m_tvalid   <= 1'b1;
            state      <= S_IDLE;
          end
        end
        S_READ: begin
          if (out_free) begin
            out_data   <= rdata;
            out_status <= ST_OK;
            out_last   <= (cmd_q != CMD_LIST) || list_done;
            m_tvalid   <= 1'b1;
            state      <= S_IDLE;
            if (cmd_q == CMD_POP_FRONT) begin
              head  <= slot;
              count <= count - CW'(1);
            end else if (cmd_q == CMD_POP_BACK) begin
              count <= count - CW'(1);
            end else if ((cmd_q == CMD_LIST) && !list_done) begin
              rem   <= rem - CW'(2);
              runs  <= runs + RUN_W'(1);
              state <= S_EXEC;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[tb/double_ended_queue_checker.sv]
`timescale 1ns / 100ps
// Result checker for the double-ended queue: predicts every request's results and compares them.
module double_ended_queue_checker #(
  parameter int DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  input  logic                       s_tready,
  input  logic [dq_pkg::DATA_W-1:0]  s_tdata,
  input  logic [dq_pkg::CMD_W-1:0]   s_tuser,
  input  logic                       m_tvalid,
  input  logic                       m_tready,
  input  logic [dq_pkg::TDATA_W-1:0] m_tdata,
  input  logic                       m_tlast,
  output int                         fail_count,
  output int                         pending
);
  import dq_pkg::*;

  localparam int SLOT_W = $clog2(DEPTH);

  typedef struct packed {
    logic [DATA_W-1:0] data;
    status_t           status;
    logic              last;
  } reply_t;

  logic [DATA_W-1:0] ring [DEPTH];
  logic [SLOT_W-1:0] front_slot;
  int                fill_level;
  reply_t            due_results [$];

  task automatic queue_reply(input logic [DATA_W-1:0] data, input status_t status,
                             input logic last);
    reply_t r;
    r.data   = data;
    r.status = status;
    r.last   = last;
    due_results.push_back(r);
  endtask

  task automatic apply_command(input logic [CMD_W-1:0] op, input logic [DATA_W-1:0] value);
    logic [SLOT_W-1:0] slot;
    int                k;
    int                n;
    case (op)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (fill_level >= DEPTH) begin
          queue_reply('0, ST_FULL, 1'b1);
        end else begin
          if (op == CMD_PUSH_FRONT) begin
            front_slot = SLOT_W'((front_slot + DEPTH - 1) % DEPTH);
            ring[front_slot] = value;
          end else begin
            slot = SLOT_W'((front_slot + fill_level) % DEPTH);
            ring[slot] = value;
          end
          fill_level++;
          queue_reply('0, ST_OK, 1'b1);
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK, CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
        if (fill_level == 0) begin
          queue_reply('0, ST_EMPTY, 1'b1);
        end else begin
          if (op == CMD_POP_FRONT || op == CMD_PEEK_FRONT) begin
            slot = front_slot;
          end else begin
            slot = SLOT_W'((front_slot + fill_level - 1) % DEPTH);
          end
          queue_reply(ring[slot], ST_OK, 1'b1);
          if (op == CMD_POP_FRONT) begin
            front_slot = SLOT_W'((front_slot + 1) % DEPTH);
            fill_level--;
          end else if (op == CMD_POP_BACK) begin
            fill_level--;
          end
        end
      end
      CMD_LIST: begin
        if (fill_level == 0) begin
          queue_reply('0, ST_EMPTY, 1'b1);
        end else begin
          n = 0;
          for (k = 0; k < fill_level && n < MAX_RESULTS; k += 2) begin
            slot = SLOT_W'((front_slot + fill_level - 1 - k) % DEPTH);
            n++;
            queue_reply(ring[slot], ST_OK, (k + 2 >= fill_level) || (n == MAX_RESULTS));
          end
        end
      end
      default: begin
        queue_reply('0, ST_OK, 1'b1);
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    reply_t want;
    if (rst) begin
      fail_count = 0;
      fill_level = 0;
      front_slot = '0;
      due_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (due_results.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result with nothing expected: data %0d status %0d last %0b",
                     $time, $signed(m_tdata[DATA_W-1:0]), m_tdata[DATA_W+STATUS_W-1:DATA_W],
                     m_tlast);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          if (m_tdata[DATA_W-1:0] !== want.data ||
              m_tdata[DATA_W+STATUS_W-1:DATA_W] !== want.status ||
              m_tlast !== want.last) begin
            if (fail_count < 10)
              $display("%0t: expected data %0d status %0d last %0b, %s %0d status %0d last %0b",
                       $time, $signed(want.data), want.status, want.last, "got data",
                       $signed(m_tdata[DATA_W-1:0]), m_tdata[DATA_W+STATUS_W-1:DATA_W],
                       m_tlast);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        apply_command(s_tuser, s_tdata);
      end
    end
    pending = due_results.size();
  end

endmodule

[tb/double_ended_queue_core_test.sv]
`timescale 1ns / 100ps
// Testbench top for the double-ended queue: stimulus, flow control and final verdict.
module double_ended_queue_core_test;
  import dq_pkg::*;

  localparam int               DEPTH           = 64;
  localparam int               RANDOM_REQUESTS = 260;
  localparam logic [CMD_W-1:0] CMD_UNUSED      = 3'd7;

  logic               clk      = 1'b0;
  logic               rst      = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [DATA_W-1:0]  s_tdata  = '0;
  logic [CMD_W-1:0]   s_tuser  = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;
  logic               m_tlast;

  int send_idle_pct = 9;
  int recv_idle_pct = 77;
  int hold_left     = 0;
  int fail_count;
  int pending;

  always #5 clk = ~clk;

  double_ended_queue_core #(.DEPTH(DEPTH)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  double_ended_queue_checker #(.DEPTH(DEPTH)) results_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // The receiver either holds off for a counted stretch or stalls at random.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] pick_command(input int pct_push, input int pct_pop);
    int roll;
    roll = $urandom_range(99);
    if (roll < pct_push) return $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
    if (roll < pct_push + pct_pop) return $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
    case ($urandom_range(3))
      0:       return CMD_PEEK_FRONT;
      1:       return CMD_PEEK_BACK;
      2:       return CMD_LIST;
      default: return CMD_UNUSED;
    endcase
  endfunction

  task automatic send_request(input logic [CMD_W-1:0] op, input logic [DATA_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  initial begin
    int               i;
    int               seg;
    logic [CMD_W-1:0] op;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Every read-type request on an empty queue, then an unused code.
    send_request(CMD_POP_FRONT, pick_value());
    send_request(CMD_POP_BACK, pick_value());
    send_request(CMD_PEEK_FRONT, pick_value());
    send_request(CMD_PEEK_BACK, pick_value());
    send_request(CMD_LIST, pick_value());
    send_request(CMD_UNUSED, pick_value());
    // Extreme values at both ends, then read them back and empty the queue again.
    send_request(CMD_PUSH_FRONT, 32'h7FFF_FFFF);
    send_request(CMD_PUSH_BACK, 32'h8000_0000);
    send_request(CMD_PUSH_FRONT, 32'h0000_0000);
    send_request(CMD_PUSH_BACK, 32'hFFFF_FFFF);
    send_request(CMD_PUSH_FRONT, 32'h5A5A_A5A5);
    send_request(CMD_LIST, pick_value());
    send_request(CMD_PEEK_FRONT, pick_value());
    send_request(CMD_PEEK_BACK, pick_value());
    send_request(CMD_POP_FRONT, pick_value());
    send_request(CMD_POP_BACK, pick_value());
    send_request(CMD_POP_BACK, pick_value());
    send_request(CMD_POP_FRONT, pick_value());
    send_request(CMD_POP_FRONT, pick_value());
    send_request(CMD_LIST, pick_value());
    wait_for_results();

    // Random bursts that fill the queue to full, mix, and drain it.
    for (i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i == 87) begin
        send_idle_pct = 77;
        recv_idle_pct = 9;
      end else if (i == 174) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (i == 40) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
        hold_left = 400;
        @(negedge clk);
      end
      if (i == 150) wait_for_results();
      seg = i % 130;
      if (seg < 75) op = pick_command(90, 4);
      else if (seg < 95) op = pick_command(30, 30);
      else op = pick_command(5, 85);
      send_request(op, pick_value());
    end

    s_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
